### rtl/core/wcs_pkg.sv
package wcs_pkg;

    // Default number of walls and the number that have a register.
    localparam int WALL_COUNT_DEF = 4;
    localparam int WALL_REGS      = 4;

    // Field and intermediate widths.
    localparam int POS_W  = 24;
    localparam int UNIT_W = 16;
    localparam int L_W    = 17;
    localparam int D_W    = 25;
    localparam int SUM_W  = 51;
    localparam int DEN_W  = 43;
    localparam int REM_W  = 59;
    localparam int Q_W    = 16;
    localparam int SEG_W  = 64;
    localparam int CIDX_W = 2;

    // Register indexes.
    localparam logic [CIDX_W-1:0] REG_WALL_A = 2'd0;
    localparam logic [CIDX_W-1:0] REG_WALL_B = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WALL_C = 2'd2;
    localparam logic [CIDX_W-1:0] REG_WALL_D = 2'd3;

    // One item as it moves through the walls.
    typedef struct packed {
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] nz;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oz;
        logic                    hit;
    } t_item;

    // Per-wall context carried through the divider.
    typedef struct packed {
        logic                     ok;
        logic signed [L_W-1:0]    lx;
        logic signed [L_W-1:0]    lz;
        logic signed [UNIT_W-1:0] x0;
        logic signed [UNIT_W-1:0] z0;
        logic [REM_W-1:0]         rem;
        logic [DEN_W-1:0]         d;
        logic [Q_W-1:0]           q;
    } t_ctx;

endpackage

### rtl/core/wcs_div.sv
module wcs_div #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  wcs_pkg::t_item i_item,
    input  wcs_pkg::t_ctx  i_ctx,
    output logic          o_valid,
    output wcs_pkg::t_item o_item,
    output wcs_pkg::t_ctx  o_ctx
);
    import wcs_pkg::*;

    localparam int B0 = Q_W - 1 - 2 * STEP;
    localparam int B1 = B0 - 1;

    logic          r_v;
    t_item         r_item;
    t_ctx          r_ctx;
    t_ctx          n_ctx;
    logic [REM_W-1:0] w_t0;
    logic [REM_W-1:0] w_t1;
    logic [REM_W-1:0] w_r1;

    // Two restoring quotient bits per stage.
    always_comb begin
        n_ctx = i_ctx;
        w_t0  = REM_W'(i_ctx.d) << B0;
        w_t1  = REM_W'(i_ctx.d) << B1;
        w_r1  = i_ctx.rem;
        if (i_ctx.rem >= w_t0) begin
            w_r1        = i_ctx.rem - w_t0;
            n_ctx.q[B0] = 1'b1;
        end
        n_ctx.rem = w_r1;
        if (w_r1 >= w_t1) begin
            n_ctx.rem   = w_r1 - w_t1;
            n_ctx.q[B1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_item <= i_item;
            r_ctx  <= n_ctx;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;
    assign o_ctx   = r_ctx;

endmodule

### rtl/core/wcs_wall.sv
module wcs_wall (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [wcs_pkg::SEG_W-1:0]   i_seg,
    input  logic                        i_valid,
    input  wcs_pkg::t_item              i_item,
    output logic                        o_valid,
    output wcs_pkg::t_item              o_item
);
    import wcs_pkg::*;

    localparam int DIV_STAGES = Q_W / 2;

    // Stage 1: differences.
    logic r1_v;
    t_item r1_item;
    logic signed [UNIT_W-1:0] r1_x0, r1_z0;
    logic signed [L_W-1:0] r1_lx, r1_lz;
    logic signed [D_W-1:0] r1_tx, r1_tz, r1_qx, r1_qz, r1_mx, r1_mz;
    logic signed [UNIT_W-1:0] w_x0, w_z0, w_x1, w_z1;
    logic signed [POS_W-1:0] w_bx, w_bz;

    assign w_x0 = i_seg[15:0];
    assign w_z0 = i_seg[31:16];
    assign w_x1 = i_seg[47:32];
    assign w_z1 = i_seg[63:48];
    assign w_bx = {w_x0, 8'h00};
    assign w_bz = {w_z0, 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_item <= i_item;
            r1_x0   <= w_x0;
            r1_z0   <= w_z0;
            r1_lx   <= L_W'(w_x1) - L_W'(w_x0);
            r1_lz   <= L_W'(w_z1) - L_W'(w_z0);
            r1_tx   <= D_W'(i_item.nx) - D_W'(w_bx);
            r1_tz   <= D_W'(i_item.nz) - D_W'(w_bz);
            r1_qx   <= D_W'(i_item.ox) - D_W'(w_bx);
            r1_qz   <= D_W'(i_item.oz) - D_W'(w_bz);
            r1_mx   <= D_W'(i_item.ox) - D_W'(i_item.nx);
            r1_mz   <= D_W'(i_item.oz) - D_W'(i_item.nz);
        end
    end

    // Stage 2: cross products.
    logic r2_v;
    t_item r2_item;
    logic signed [UNIT_W-1:0] r2_x0, r2_z0;
    logic signed [L_W-1:0] r2_lx, r2_lz;
    logic signed [SUM_W-2:0] r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6, r2_p7, r2_p8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_item <= r1_item;
            r2_x0   <= r1_x0;
            r2_z0   <= r1_z0;
            r2_lx   <= r1_lx;
            r2_lz   <= r1_lz;
            r2_p1   <= (SUM_W-1)'(r1_lz * r1_tx);
            r2_p2   <= (SUM_W-1)'(r1_lx * r1_tz);
            r2_p3   <= (SUM_W-1)'(r1_lz * r1_qx);
            r2_p4   <= (SUM_W-1)'(r1_lx * r1_qz);
            r2_p5   <= (SUM_W-1)'(r1_lz * r1_mx);
            r2_p6   <= (SUM_W-1)'(r1_lx * r1_mz);
            r2_p7   <= (SUM_W-1)'(r1_tz * r1_mx);
            r2_p8   <= (SUM_W-1)'(r1_tx * r1_mz);
        end
    end

    // Stage 3: side tests, denominator and numerator.
    logic r3_v;
    t_item r3_item;
    logic signed [UNIT_W-1:0] r3_x0, r3_z0;
    logic signed [L_W-1:0] r3_lx, r3_lz;
    logic signed [DEN_W-1:0] r3_sn, r3_so, r3_den;
    logic signed [SUM_W-1:0] r3_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_item <= r2_item;
            r3_x0   <= r2_x0;
            r3_z0   <= r2_z0;
            r3_lx   <= r2_lx;
            r3_lz   <= r2_lz;
            r3_sn   <= DEN_W'(r2_p1) - DEN_W'(r2_p2);
            r3_so   <= DEN_W'(r2_p3) - DEN_W'(r2_p4);
            r3_den  <= DEN_W'(r2_p5) - DEN_W'(r2_p6);
            r3_num  <= SUM_W'(r2_p7) - SUM_W'(r2_p8);
        end
    end

    // Stage 4: magnitudes and the hit test; the fraction must lie in [1/256, 256).
    logic r4_v;
    t_item r4_item;
    t_ctx r4_ctx;
    t_ctx n4_ctx;
    logic [SUM_W-1:0] w_anum;
    logic [DEN_W-1:0] w_aden;
    logic w_side_ok;

    always_comb begin
        w_anum    = r3_num[SUM_W-1] ? SUM_W'(-r3_num) : SUM_W'(r3_num);
        w_aden    = r3_den[DEN_W-1] ? DEN_W'(-r3_den) : DEN_W'(r3_den);
        w_side_ok = (r3_sn[DEN_W-1] || (r3_sn == '0)) &&
                    ((r3_sn == '0) || !r3_so[DEN_W-1]);
        n4_ctx.lx  = r3_lx;
        n4_ctx.lz  = r3_lz;
        n4_ctx.x0  = r3_x0;
        n4_ctx.z0  = r3_z0;
        n4_ctx.rem = {w_anum, 8'h00};
        n4_ctx.d   = w_aden;
        n4_ctx.q   = '0;
        n4_ctx.ok  = (r3_den != '0) && (r3_num != '0) && w_side_ok &&
                     (r3_num[SUM_W-1] == r3_den[DEN_W-1]) &&
                     ({w_anum, 8'h00} >= REM_W'(w_aden)) &&
                     (REM_W'(w_anum) < (REM_W'(w_aden) << 8));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            r4_item <= r3_item;
            r4_ctx  <= n4_ctx;
        end
    end

    // Divider stages.
    logic  w_dv [DIV_STAGES+1];
    t_item w_di [DIV_STAGES+1];
    t_ctx  w_dc [DIV_STAGES+1];

    assign w_dv[0] = r4_v;
    assign w_di[0] = r4_item;
    assign w_dc[0] = r4_ctx;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        wcs_div #(.STEP(k)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_dv[k]),
            .i_item  (w_di[k]),
            .i_ctx   (w_dc[k]),
            .o_valid (w_dv[k+1]),
            .o_item  (w_di[k+1]),
            .o_ctx   (w_dc[k+1])
        );
    end

    // Stage after the divider: offsets along the wall.
    logic r5_v;
    t_item r5_item;
    logic r5_ok;
    logic signed [UNIT_W-1:0] r5_x0, r5_z0;
    logic signed [2*L_W-1:0] r5_px, r5_pz;
    t_ctx w_c;

    assign w_c = w_dc[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= w_dv[DIV_STAGES];
        end
        if (i_en) begin
            r5_item <= w_di[DIV_STAGES];
            r5_ok   <= w_c.ok;
            r5_x0   <= w_c.x0;
            r5_z0   <= w_c.z0;
            r5_px   <= w_c.lx * $signed({1'b0, w_c.q});
            r5_pz   <= w_c.lz * $signed({1'b0, w_c.q});
        end
    end

    // Final stage: snap the new point on a hit, offsets truncated toward zero.
    logic r6_v;
    t_item r6_item;
    t_item n6_item;
    logic signed [2*L_W-1:0] w_rx, w_rz;
    logic signed [POS_W+1:0] w_sx, w_sz;

    always_comb begin
        w_rx = r5_px + (r5_px[2*L_W-1] ? (2*L_W)'(255) : '0);
        w_rz = r5_pz + (r5_pz[2*L_W-1] ? (2*L_W)'(255) : '0);
        w_sx = (POS_W+2)'($signed({r5_x0, 8'h00})) + (POS_W+2)'(w_rx >>> 8);
        w_sz = (POS_W+2)'($signed({r5_z0, 8'h00})) + (POS_W+2)'(w_rz >>> 8);
        n6_item = r5_item;
        if (r5_ok) begin
            n6_item.nx  = w_sx[POS_W-1:0];
            n6_item.nz  = w_sz[POS_W-1:0];
            n6_item.hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= r5_v;
        end
        if (i_en) begin
            r6_item <= n6_item;
        end
    end

    assign o_valid = r6_v;
    assign o_item  = r6_item;

endmodule

### rtl/core/wall_crossing_snap.sv
// Channel   Direction  Contents
// s_axis    in         tdata: new_x, new_z, old_x, old_z (24 bits each)
// m_axis    out        tdata: out_x, out_z (24 bits each); tuser: hit
// cfg       in         write enable, index 0..3, 64-bit wall segment
//
// One item enters per cycle unless the output stalls. Each wall has four stages
// for the differences, products, sums and hit test, eight two-bit fraction
// divider stages, and two stages that scale the offsets and snap the point.
// Synchronous active-low reset clears all valid bits and the wall registers.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
module wall_crossing_snap #(
    parameter int WALL_COUNT = wcs_pkg::WALL_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // new_x [23:0], new_z [47:24], old_x [71:48], old_z [95:72]
    input  logic [95:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_x [23:0], out_z [47:24]
    output logic [47:0]                  m_axis_tdata,
    // hit [0]
    output logic [0:0]                   m_axis_tuser,
    input  logic                         i_cfg_we,
    input  logic [wcs_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [wcs_pkg::SEG_W-1:0]    i_cfg_data
);
    import wcs_pkg::*;

    logic [SEG_W-1:0] r_wall [WALL_REGS];
    logic  w_en;
    logic  w_v [WALL_COUNT+1];
    t_item w_i [WALL_COUNT+1];

    // Wall register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WALL_REGS; k++) begin
                r_wall[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WALL_A: r_wall[0] <= i_cfg_data;
                REG_WALL_B: r_wall[1] <= i_cfg_data;
                REG_WALL_C: r_wall[2] <= i_cfg_data;
                REG_WALL_D: r_wall[3] <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Whole pipeline advances unless the output holds a result not taken.
    assign w_en          = !w_v[WALL_COUNT] || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_v[0]    = s_axis_tvalid;
    assign w_i[0].nx = s_axis_tdata[23:0];
    assign w_i[0].nz = s_axis_tdata[47:24];
    assign w_i[0].ox = s_axis_tdata[71:48];
    assign w_i[0].oz = s_axis_tdata[95:72];
    assign w_i[0].hit = 1'b0;

    for (genvar w = 0; w < WALL_COUNT; w++) begin : g_wall
        logic [SEG_W-1:0] w_seg;
        if (w < WALL_REGS) begin : g_reg
            assign w_seg = r_wall[w];
        end else begin : g_none
            assign w_seg = '0;
        end
        wcs_wall u_wall (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_seg   (w_seg),
            .i_valid (w_v[w]),
            .i_item  (w_i[w]),
            .o_valid (w_v[w+1]),
            .o_item  (w_i[w+1])
        );
    end

    assign m_axis_tvalid   = w_v[WALL_COUNT];
    assign m_axis_tdata    = {w_i[WALL_COUNT].nz, w_i[WALL_COUNT].nx};
    assign m_axis_tuser[0] = w_i[WALL_COUNT].hit;

    // The input is refused exactly while a result waits.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipeline stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
